### src/dsti64_pkg.sv
`default_nettype none

package dsti64_pkg;

    // parse phase codes
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_FAIL  = 2'd3;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] RADIX    = 8'd10;

    // finished string handed from the parser to the output stage
    typedef struct packed {
        logic        good;
        logic        neg;
        logic [63:0] mag;
    } t_fin;

endpackage

`default_nettype wire

### src/decimal_string_to_int64.sv
// Decimal string to signed 64-bit integer.
// Input channel (i_valid / o_stall): one beat per character of the string,
// i_is_last on the final beat; i_no_char marks a beat with no character,
// used to close an empty string. Output channel (o_valid / i_stall): one
// beat per string, following its last input beat, with o_value and o_ok.
// A string is taken at one character per cycle while o_stall is low, back
// to back, strings following each other with no gap. The last character
// passes through the input register, then the parser stage (multiply by
// ten, add and overflow check), then the output register (sign applied);
// a stall can hold it between any two of these.
// Reset clears the parse state and empties all stages.
// When the receiver stalls, the held result stays on the outputs; the
// parser keeps taking characters of the next string until a second
// result reaches the stage behind the output register, and o_stall rises
// once the input register also holds a beat.
`default_nettype none

module decimal_string_to_int64 (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_char_code,
    input  wire logic               i_is_last,
    input  wire logic               i_no_char,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [63:0]      o_value,
    output logic                    o_ok
);

    logic              r_in_valid;
    logic [7:0]        r_char_code;
    logic              r_is_last;
    logic              r_no_char;
    logic              fin_valid;
    dsti64_pkg::t_fin  fin;
    logic              adv_out;
    logic              adv_fin;
    logic              adv_in;
    logic              take;

    // each stage loads when empty or when its content moves on
    assign adv_out = !o_valid || !i_stall;
    assign adv_fin = !fin_valid || adv_out;
    assign take    = r_in_valid && adv_fin;
    assign adv_in  = !r_in_valid || adv_fin;
    assign o_stall = !adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_valid) begin
            r_char_code <= i_char_code;
            r_is_last   <= i_is_last;
            r_no_char   <= i_no_char;
        end
    end

    dsti64_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_adv       (adv_fin),
        .i_char_code (r_char_code),
        .i_is_last   (r_is_last),
        .i_no_char   (r_no_char),
        .o_fin_valid (fin_valid),
        .o_fin       (fin)
    );

    dsti64_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv_out),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_ok        (o_ok)
    );

endmodule

`default_nettype wire

### src/dsti64_core.sv
`default_nettype none

module dsti64_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic             i_adv,
    input  wire logic [7:0]       i_char_code,
    input  wire logic             i_is_last,
    input  wire logic             i_no_char,
    output logic                  o_fin_valid,
    output dsti64_pkg::t_fin      o_fin
);

    logic [1:0]        r_phase;
    logic [1:0]        n_phase;
    logic              r_neg;
    logic              n_neg;
    logic [63:0]       r_mag;
    logic [63:0]       n_mag;
    logic              r_fin_valid;
    dsti64_pkg::t_fin  r_fin;
    dsti64_pkg::t_fin  n_fin;

    always_comb begin
        logic [7:0]  dig;
        logic        is_digit;
        logic [67:0] prod;
        logic        skip;

        dig      = i_char_code - dsti64_pkg::CH_ZERO;
        is_digit = dig < dsti64_pkg::RADIX;
        // mag * 10 + digit, carries above bit 63 mean overflow
        prod     = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + {60'b0, dig};
        skip     = 1'b0;

        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;

        if (!i_no_char) begin
            if (n_phase == dsti64_pkg::PH_START) begin
                n_phase = dsti64_pkg::PH_INT;
                if (i_char_code == dsti64_pkg::CH_MINUS) begin
                    n_neg = 1'b1;
                    skip  = 1'b1;
                end
            end
            if (!skip) begin
                case (n_phase)
                    dsti64_pkg::PH_INT: begin
                        if (is_digit) begin
                            if (prod[67:64] != 4'd0) begin
                                n_phase = dsti64_pkg::PH_FAIL;
                            end else begin
                                n_mag = prod[63:0];
                            end
                        end else if (i_char_code == dsti64_pkg::CH_DOT) begin
                            n_phase = dsti64_pkg::PH_FRAC;
                        end else begin
                            n_phase = dsti64_pkg::PH_FAIL;
                        end
                    end
                    dsti64_pkg::PH_FRAC: begin
                        if (!is_digit) begin
                            n_phase = dsti64_pkg::PH_FAIL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // magnitude may reach 2^63 only for a negative string
        n_fin.good = (n_phase != dsti64_pkg::PH_FAIL) &&
                     (!n_mag[63] || (n_neg && (n_mag[62:0] == 63'd0)));
        n_fin.neg  = n_neg;
        n_fin.mag  = n_mag;

        if (i_is_last) begin
            n_phase = dsti64_pkg::PH_START;
            n_neg   = 1'b0;
            n_mag   = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dsti64_pkg::PH_START;
            r_neg       <= 1'b0;
            r_mag       <= 64'd0;
            r_fin_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_mag   <= n_mag;
            end
            if (i_adv) begin
                r_fin_valid <= i_take && i_is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_is_last) begin
            r_fin <= n_fin;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

endmodule

`default_nettype wire

### src/dsti64_out.sv
`default_nettype none

module dsti64_out (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_fin_valid,
    input  wire dsti64_pkg::t_fin    i_fin,
    output logic                     o_valid,
    output logic signed [63:0]       o_value,
    output logic                     o_ok
);

    logic               r_valid;
    logic signed [63:0] r_value;
    logic               r_ok;
    logic signed [63:0] n_value;

    always_comb begin
        if (!i_fin.good) begin
            n_value = 64'sd0;
        end else if (i_fin.neg) begin
            n_value = $signed(64'd0 - i_fin.mag);
        end else begin
            n_value = $signed(i_fin.mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_fin_valid) begin
            r_value <= n_value;
            r_ok    <= i_fin.good;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_ok    = r_ok;

endmodule

`default_nettype wire

### verif/decimal_string_to_int64_tb.sv
`timescale 1ns / 100ps

module decimal_string_to_int64_tb;

    localparam int HOLD_CYCLES = 90;
    localparam int WATCHDOG    = 3000;
    localparam int PHASE_BEATS = 380;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       empty;
    } t_char_beat;

    typedef struct packed {
        logic signed [63:0] value;
        logic               ok;
    } t_parsed_int;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_char_code = 8'd0;
    logic               i_is_last = 1'b0;
    logic               i_no_char = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [63:0] o_value;
    logic               o_ok;

    decimal_string_to_int64 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .i_no_char   (i_no_char),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_ok        (o_ok)
    );

    always #2 i_clk = ~i_clk;

    t_char_beat  pending_beats[$];
    t_parsed_int expected_ints[$];
    logic [7:0]  word_chars[$];

    // parser state mirrored by the predictor
    logic [1:0]  prs_phase = dsti64_pkg::PH_START;
    logic        prs_neg = 1'b0;
    logic [63:0] prs_mag = 64'd0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;

    int errors = 0;
    int beats_counted = 0;
    int strings_sent = 0;
    int beats_taken = 0;
    int results_checked = 0;
    int quiet_cycles = 0;
    int block_stall_cycles = 0;

    t_char_beat  next_beat;
    t_parsed_int got_int;

    task automatic parse_beat(input logic [7:0] code, input logic last, input logic empty);
        logic [7:0]  d;
        logic [67:0] acc;
        logic [63:0] lim;
        logic        sign_only;
        t_parsed_int res;
        sign_only = 1'b0;
        if (!empty) begin
            d = code - dsti64_pkg::CH_ZERO;
            if (prs_phase == dsti64_pkg::PH_START) begin
                if (code == dsti64_pkg::CH_MINUS) begin
                    prs_neg = 1'b1;
                    sign_only = 1'b1;
                end
                prs_phase = dsti64_pkg::PH_INT;
            end
            if (!sign_only) begin
                if (prs_phase == dsti64_pkg::PH_INT) begin
                    if (d < dsti64_pkg::RADIX) begin
                        // a carry into the top nibble means unsigned 64-bit overflow
                        acc = {4'd0, prs_mag} * 68'd10 + {60'd0, d};
                        if (acc[67:64] != 4'd0)
                            prs_phase = dsti64_pkg::PH_FAIL;
                        else
                            prs_mag = acc[63:0];
                    end else if (code == dsti64_pkg::CH_DOT) begin
                        prs_phase = dsti64_pkg::PH_FRAC;
                    end else begin
                        prs_phase = dsti64_pkg::PH_FAIL;
                    end
                end else if (prs_phase == dsti64_pkg::PH_FRAC) begin
                    if (!(d < dsti64_pkg::RADIX))
                        prs_phase = dsti64_pkg::PH_FAIL;
                end
            end
        end
        if (last) begin
            lim = 64'h7FFF_FFFF_FFFF_FFFF + {63'd0, prs_neg};
            if (prs_phase != dsti64_pkg::PH_FAIL && prs_mag <= lim) begin
                res.value = prs_neg ? -prs_mag : prs_mag;
                res.ok = 1'b1;
            end else begin
                res.value = 64'sd0;
                res.ok = 1'b0;
            end
            expected_ints.push_back(res);
            prs_phase = dsti64_pkg::PH_START;
            prs_neg = 1'b0;
            prs_mag = 64'd0;
        end
    endtask

    task automatic push_beat(input logic [7:0] code, input logic last, input logic empty);
        t_char_beat b;
        b.code = code;
        b.last = last;
        b.empty = empty;
        pending_beats.push_back(b);
        // a characterless beat that does not end a string changes nothing
        if (!(empty && !last))
            beats_counted++;
        if (last)
            strings_sent++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], i == s.len() - 1, 1'b0);
    endtask

    task automatic emit_string(input int gap_pct);
        bit empty_end;
        int n;
        n = word_chars.size();
        empty_end = (n == 0) || ($urandom_range(99) < 15);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < gap_pct)
                push_beat(8'($urandom_range(255)), 1'b0, 1'b1);
            push_beat(word_chars[i], (i == n - 1) && !empty_end, 1'b0);
        end
        if (empty_end)
            push_beat(8'($urandom_range(255)), 1'b1, 1'b1);
        word_chars.delete();
    endtask

    task automatic append_decimal(input logic [64:0] v);
        logic [7:0] digs[$];
        do begin
            digs.push_front(dsti64_pkg::CH_ZERO + 8'(v % 65'd10));
            v = v / 65'd10;
        end while (v != 65'd0);
        foreach (digs[i])
            word_chars.push_back(digs[i]);
    endtask

    task automatic build_number(input bit allow_frac);
        int nd;
        if ($urandom_range(99) < 30)
            word_chars.push_back(dsti64_pkg::CH_MINUS);
        nd = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
        repeat (nd)
            word_chars.push_back(dsti64_pkg::CH_ZERO + 8'($urandom_range(9)));
        if (allow_frac && $urandom_range(99) < 25) begin
            word_chars.push_back(dsti64_pkg::CH_DOT);
            repeat ($urandom_range(4))
                word_chars.push_back(dsti64_pkg::CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic make_random_string();
        int kind;
        int pick;
        int pos;
        logic [64:0] v;
        logic [7:0] bad;
        kind = $urandom_range(99);
        if (kind < 45) begin
            build_number(1'b1);
        end else if (kind < 60) begin
            // around the signed limit, the unsigned limit, or anywhere in 64 bits
            pick = $urandom_range(2);
            if (pick == 0)
                v = 65'h0_8000_0000_0000_0000;
            else if (pick == 1)
                v = 65'h1_0000_0000_0000_0000;
            else
                v = {1'b0, $urandom, $urandom};
            v = v + 65'($urandom_range(6)) - 65'd3;
            if ($urandom_range(1) == 1)
                word_chars.push_back(dsti64_pkg::CH_MINUS);
            append_decimal(v);
            if ($urandom_range(99) < 20) begin
                word_chars.push_back(dsti64_pkg::CH_DOT);
                word_chars.push_back(dsti64_pkg::CH_ZERO + 8'($urandom_range(9)));
            end
        end else if (kind < 70) begin
            pick = $urandom_range(5);
            if (pick == 1 || pick == 3 || pick == 5)
                word_chars.push_back(dsti64_pkg::CH_MINUS);
            if (pick >= 2 && pick <= 4)
                word_chars.push_back(dsti64_pkg::CH_DOT);
            if (pick >= 4)
                repeat ($urandom_range(3, 1))
                    word_chars.push_back(dsti64_pkg::CH_ZERO + 8'($urandom_range(9)));
        end else if (kind < 85) begin
            build_number(1'b1);
            pick = $urandom_range(2);
            if (pick == 0)
                bad = dsti64_pkg::CH_MINUS;
            else if (pick == 1)
                bad = dsti64_pkg::CH_DOT;
            else
                bad = 8'($urandom_range(255));
            pos = $urandom_range(word_chars.size());
            word_chars.insert(pos, bad);
        end else begin
            repeat ($urandom_range(6, 1)) begin
                pick = $urandom_range(5);
                if (pick < 3)
                    word_chars.push_back(8'($urandom_range(255)));
                else if (pick == 3)
                    word_chars.push_back($urandom_range(1) ? dsti64_pkg::CH_MINUS
                                                           : dsti64_pkg::CH_DOT);
                else
                    word_chars.push_back(dsti64_pkg::CH_ZERO + 8'($urandom_range(10))
                                         - 8'd1);
            end
        end
        emit_string(4);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_valid || expected_ints.size() != 0)
            @(negedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_beat(i_char_code, i_is_last, i_no_char);
                beats_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = pending_beats.pop_front();
                    i_valid <= 1'b1;
                    i_char_code <= next_beat.code;
                    i_is_last <= next_beat.last;
                    i_no_char <= next_beat.empty;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            i_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_ints.size() == 0) begin
                $display("%0t: result with none expected: value %0d ok %0b",
                         $time, o_value, o_ok);
                errors++;
            end else begin
                got_int = expected_ints.pop_front();
                results_checked++;
                if (o_value !== got_int.value) begin
                    $display("%0t: value mismatch: expected %0d actual %0d",
                             $time, got_int.value, o_value);
                    errors++;
                end
                if (o_ok !== got_int.ok) begin
                    $display("%0t: ok mismatch: expected %0b actual %0b",
                             $time, got_int.ok, o_ok);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_stall === 1'b1)
            block_stall_cycles <= block_stall_cycles + 1;
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
            $display("decimal_string_to_int64_tb failed");
            $finish;
        end
    end

    int send_pct [4] = '{0, 69, 0, 17};
    int recv_pct [4] = '{0, 0, 69, 17};

    initial begin
        int target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty string, lone sign and dot, sign in the wrong place, gap beats, bad characters
        push_beat(8'h5A, 1'b1, 1'b1);
        queue_text("-");
        queue_text(".");
        queue_text("-.");
        queue_text("1-");
        push_beat(8'hA5, 1'b0, 1'b1);
        queue_text("7");
        queue_text("x5");
        queue_text("3.9");
        push_beat("4", 1'b0, 1'b0);
        push_beat(8'hFF, 1'b1, 1'b1);
        push_beat(8'hFF, 1'b1, 1'b0);
        push_beat(8'h00, 1'b1, 1'b0);
        queue_text("9:");
        queue_text("-0");
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            target = beats_counted + PHASE_BEATS;
            while (beats_counted < target)
                make_random_string();
            wait_drained();
        end

        // long output hold while short strings keep arriving
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        repeat (40) begin
            build_number(1'b0);
            emit_string(0);
        end
        while (hold_cnt < HOLD_CYCLES)
            @(negedge i_clk);
        hold_req = 1'b0;
        wait_drained();

        repeat (8) @(negedge i_clk);
        $display("covered %0d strings in %0d beats, %0d results checked, %0d mismatches",
                 strings_sent, beats_taken, results_checked, errors);
        $display("input held off by the block for %0d cycles under output back-pressure",
                 block_stall_cycles);
        if (errors == 0 && expected_ints.size() == 0)
            $display("decimal_string_to_int64_tb passed");
        else
            $display("decimal_string_to_int64_tb failed");
        $finish;
    end

endmodule
